// ===== rtl/pfc_pkg.sv =====
// Package: shared types, constants and square geometry for the Playfair engine
`default_nettype none
package pfc_pkg;

    localparam int unsigned SQ_SIDE    = 5;
    localparam int unsigned SQ_SIZE    = 25;
    localparam int unsigned LETTERS    = 26;
    localparam int unsigned IDX_W      = 5;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned COORD_W    = 3;

    localparam logic [IDX_W-1:0] LETTER_I = 5'd8;
    localparam logic [IDX_W-1:0] LETTER_J = 5'd9;
    localparam logic [IDX_W-1:0] LETTER_X = 5'd23;
    localparam logic [IDX_W-1:0] LETTER_Z = 5'd25;
    localparam logic [POS_W-1:0] SQ_FULL  = 5'd25;

    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
    localparam logic [6:0] OUT_BASE_A    = 7'd65;

    typedef enum logic [2:0] {
        CMD_BEGIN_KEY  = 3'd0,
        CMD_KEY_CHAR   = 3'd1,
        CMD_FINISH_KEY = 3'd2,
        CMD_TEXT_CHAR  = 3'd3,
        CMD_END_MSG    = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_RD_A,
        ST_RD_B,
        ST_CALC,
        ST_KEY1,
        ST_OUT1,
        ST_OUT2
    } state_t;

    // row of a square position
    function automatic logic [COORD_W-1:0] pfc_row(input logic [POS_W-1:0] p);
        logic [COORD_W-1:0] r;
        if (p < 5'd5)       r = 3'd0;
        else if (p < 5'd10) r = 3'd1;
        else if (p < 5'd15) r = 3'd2;
        else if (p < 5'd20) r = 3'd3;
        else                r = 3'd4;
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pfc_place(input logic [COORD_W-1:0] r,
                                                   input logic [COORD_W-1:0] c);
        logic [POS_W-1:0] r5;
        r5 = {r, 2'b00} + {2'b00, r};
        return r5 + {2'b00, c};
    endfunction

    function automatic logic [COORD_W-1:0] pfc_col(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] base;
        logic [POS_W-1:0] diff;
        base = pfc_place(pfc_row(p), 3'd0);
        diff = p - base;
        return diff[COORD_W-1:0];
    endfunction

    // step one coordinate forward (enciphering) or backward, modulo the side
    function automatic logic [COORD_W-1:0] pfc_step(input logic [COORD_W-1:0] x,
                                                    input logic back);
        logic [COORD_W-1:0] y;
        if (back) y = (x == 3'd0) ? 3'd4 : x - 3'd1;
        else      y = (x == 3'd4) ? 3'd0 : x + 3'd1;
        return y;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pfc_ram.sv =====
// Generic simple dual-port RAM with registered read
`default_nettype none
module pfc_ram #(
    parameter int unsigned DATA_WIDTH = 5,
    parameter int unsigned DEPTH      = 25
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire logic [DATA_WIDTH-1:0]        wr_data,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic      [DATA_WIDTH-1:0]        rd_data
);
    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/playfair_cipher_engine_top.sv =====
// Top level: Playfair 5x5 key-square builder and pair cipher
// Timing: key character and begin key are handled in the idle state; finish key walks the 26-letter
//   alphabet once. A completing text request passes through RD_A, RD_B, CALC, KEY1 and OUT1 before
//   its first letter is presented; the second one follows from OUT2 if the sink is ready.
// Pairs are handled one at a time (s_ready only in idle), bounded by the sequential reads of the letter-place
//   RAM (two places) and the key-square RAM (two letters) through single read ports.
// Reset (aresetn, synchronous, active low): letter map unused, fill count zero, nothing held,
//   enciphering; key-square contents are undefined until written. No clearing pass.
`default_nettype none
module playfair_cipher_engine_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    // request channel
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_command,
    input  wire logic [7:0] s_character,
    // result channel
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [6:0] m_letter,
    output logic            m_last
);
    import pfc_pkg::*;

    // control state
    state_t               state_reg,      state_next;
    logic [POS_W-1:0]     fill_count_reg, fill_count_next;
    logic [LETTERS-1:0]   place_valid_reg, place_valid_next;   // letter_place "placed" bits
    logic [IDX_W-1:0]     held_letter_reg, held_letter_next;
    logic                 held_valid_reg,  held_valid_next;
    logic [IDX_W-1:0]     fill_idx_reg,    fill_idx_next;
    logic                 decrypt_mode_reg;
    logic                 m_valid_reg,     m_valid_next;

    // datapath of the pair being worked on
    logic [IDX_W-1:0]     a_reg,  a_next;
    logic [IDX_W-1:0]     b_reg,  b_next;
    logic [POS_W-1:0]     pa_reg, pa_next;
    logic [POS_W-1:0]     q1_reg, q1_next;
    logic [POS_W-1:0]     q2_reg, q2_next;
    logic [6:0]           m_letter_reg, m_letter_next;
    logic                 m_last_reg,   m_last_next;

    // RAM ports
    logic                 sq_wr_en, sq_rd_en;
    logic [POS_W-1:0]     sq_wr_addr, sq_rd_addr;
    logic [IDX_W-1:0]     sq_wr_data, sq_rd_data;
    logic                 pl_wr_en, pl_rd_en;
    logic [IDX_W-1:0]     pl_wr_addr, pl_rd_addr;
    logic [POS_W-1:0]     pl_wr_data, pl_rd_data;

    // character decode: letter index with J folded onto I
    logic                 is_upper, is_lower, is_letter;
    logic [7:0]           ch_off;
    logic [IDX_W-1:0]     ch_idx;

    // pair geometry
    logic [POS_W-1:0]     pb;
    logic [COORD_W-1:0]   r1, c1, r2, c2;
    logic                 out_free;

    // key square: letter index per position; letter map: position per letter
    pfc_ram #(.DATA_WIDTH(IDX_W), .DEPTH(SQ_SIZE)) u_key_square (
        .aclk    (aclk),
        .wr_en   (sq_wr_en),
        .wr_addr (sq_wr_addr),
        .wr_data (sq_wr_data),
        .rd_en   (sq_rd_en),
        .rd_addr (sq_rd_addr),
        .rd_data (sq_rd_data)
    );

    pfc_ram #(.DATA_WIDTH(POS_W), .DEPTH(LETTERS)) u_letter_place (
        .aclk    (aclk),
        .wr_en   (pl_wr_en),
        .wr_addr (pl_wr_addr),
        .wr_data (pl_wr_data),
        .rd_en   (pl_rd_en),
        .rd_addr (pl_rd_addr),
        .rd_data (pl_rd_data)
    );

    always_comb begin
        is_upper  = (s_character >= ASCII_UPPER_A) && (s_character <= ASCII_UPPER_Z);
        is_lower  = (s_character >= ASCII_LOWER_A) && (s_character <= ASCII_LOWER_Z);
        is_letter = is_upper || is_lower;
        ch_off    = is_upper ? (s_character - ASCII_UPPER_A) : (s_character - ASCII_LOWER_A);
        ch_idx    = (ch_off[IDX_W-1:0] == LETTER_J) ? LETTER_I : ch_off[IDX_W-1:0];
    end

    // unplaced letters read as position 0
    assign pb = place_valid_reg[b_reg] ? pl_rd_data : '0;
    assign r1 = pfc_row(pa_reg);
    assign c1 = pfc_col(pa_reg);
    assign r2 = pfc_row(pb);
    assign c2 = pfc_col(pb);

    // output register can take a letter this cycle
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_letter = m_letter_reg;
    assign m_last   = m_last_reg;

    always_comb begin
        state_next       = state_reg;
        fill_count_next  = fill_count_reg;
        place_valid_next = place_valid_reg;
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        fill_idx_next    = fill_idx_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        a_next           = a_reg;
        b_next           = b_reg;
        pa_next          = pa_reg;
        q1_next          = q1_reg;
        q2_next          = q2_reg;
        m_letter_next    = m_letter_reg;
        m_last_next      = m_last_reg;

        sq_wr_en   = 1'b0;
        sq_wr_addr = fill_count_reg;
        sq_wr_data = ch_idx;
        sq_rd_en   = 1'b0;
        sq_rd_addr = q1_reg;
        pl_wr_en   = 1'b0;
        pl_wr_addr = ch_idx;
        pl_wr_data = fill_count_reg;
        pl_rd_en   = 1'b0;
        pl_rd_addr = a_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_command)
                        CMD_BEGIN_KEY: begin
                            place_valid_next = '0;
                            fill_count_next  = '0;
                        end
                        CMD_KEY_CHAR: begin
                            if (is_letter && !place_valid_reg[ch_idx]
                                && (fill_count_reg < SQ_FULL)) begin
                                sq_wr_en                 = 1'b1;
                                pl_wr_en                 = 1'b1;
                                place_valid_next[ch_idx] = 1'b1;
                                fill_count_next          = fill_count_reg + 5'd1;
                            end
                        end
                        CMD_FINISH_KEY: begin
                            fill_idx_next = '0;
                            state_next    = ST_FILL;
                        end
                        CMD_TEXT_CHAR: begin
                            if (is_letter) begin
                                if (!held_valid_reg) begin
                                    held_letter_next = ch_idx;
                                    held_valid_next  = 1'b1;
                                end else begin
                                    // equal letters: pair with X, keep the second held
                                    a_next = held_letter_reg;
                                    if (ch_idx == held_letter_reg) begin
                                        b_next = LETTER_X;
                                    end else begin
                                        b_next          = ch_idx;
                                        held_valid_next = 1'b0;
                                    end
                                    state_next = ST_RD_A;
                                end
                            end
                        end
                        CMD_END_MSG: begin
                            if (held_valid_reg) begin
                                a_next          = held_letter_reg;
                                b_next          = LETTER_X;
                                held_valid_next = 1'b0;
                                state_next      = ST_RD_A;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                // append unused letters of the J-less alphabet
                sq_wr_data = fill_idx_reg;
                pl_wr_addr = fill_idx_reg;
                if ((fill_idx_reg != LETTER_J) && !place_valid_reg[fill_idx_reg]
                    && (fill_count_reg < SQ_FULL)) begin
                    sq_wr_en                       = 1'b1;
                    pl_wr_en                       = 1'b1;
                    place_valid_next[fill_idx_reg] = 1'b1;
                    fill_count_next                = fill_count_reg + 5'd1;
                end
                fill_idx_next = fill_idx_reg + 5'd1;
                if (fill_idx_reg == LETTER_Z) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_A: begin
                pl_rd_en   = 1'b1;
                pl_rd_addr = a_reg;
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                pl_rd_en   = 1'b1;
                pl_rd_addr = b_reg;
                pa_next    = place_valid_reg[a_reg] ? pl_rd_data : '0;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (r1 == r2) begin
                    q1_next = pfc_place(r1, pfc_step(c1, decrypt_mode_reg));
                    q2_next = pfc_place(r2, pfc_step(c2, decrypt_mode_reg));
                end else if (c1 == c2) begin
                    q1_next = pfc_place(pfc_step(r1, decrypt_mode_reg), c1);
                    q2_next = pfc_place(pfc_step(r2, decrypt_mode_reg), c2);
                end else begin
                    q1_next = pfc_place(r1, c2);
                    q2_next = pfc_place(r2, c1);
                end
                state_next = ST_KEY1;
            end
            ST_KEY1: begin
                sq_rd_en   = 1'b1;
                sq_rd_addr = q1_reg;
                state_next = ST_OUT1;
            end
            ST_OUT1: begin
                // read data holds until the next read is issued
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_letter_next = OUT_BASE_A + {2'b00, sq_rd_data};
                    m_last_next   = 1'b0;
                    sq_rd_en      = 1'b1;
                    sq_rd_addr    = q2_reg;
                    state_next    = ST_OUT2;
                end
            end
            ST_OUT2: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_letter_next = OUT_BASE_A + {2'b00, sq_rd_data};
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            fill_count_reg   <= '0;
            place_valid_reg  <= '0;
            held_letter_reg  <= '0;
            held_valid_reg   <= 1'b0;
            fill_idx_reg     <= '0;
            decrypt_mode_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg       <= state_next;
            fill_count_reg  <= fill_count_next;
            place_valid_reg <= place_valid_next;
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
            fill_idx_reg    <= fill_idx_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                decrypt_mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        pa_reg       <= pa_next;
        q1_reg       <= q1_next;
        q2_reg       <= q2_next;
        m_letter_reg <= m_letter_next;
        m_last_reg   <= m_last_next;
    end

`ifndef SYNTH
    // square never overfills
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= SQ_FULL)
        else $error("fill count beyond square size");

    // every placed letter owns exactly one square entry
    a_fill_matches_map: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(place_valid_reg) == 32'(fill_count_reg))
        else $error("placed-letter count differs from fill count");

    // J is never placed
    a_no_j: assert property (@(posedge aclk) disable iff (!aresetn)
        !place_valid_reg[LETTER_J])
        else $error("letter J placed in square");

    // second letter of a pair follows its issue stage
    a_second_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT2 && out_free) |=> (m_valid && m_last))
        else $error("second letter of pair not presented");
`endif

endmodule
`default_nettype wire
